// ===== src/lgs_pkg.sv =====
// Package for the lookahead goal selector: codes, microcode format and program.
package lgs_pkg;

  localparam int DEF_MAX_POINTS = 1024;
  localparam int DEF_COORD_BITS = 24;
  localparam int LA_W           = 49;
  localparam logic [LA_W-1:0] LA_RESET = 49'd1048576;
  localparam int OUT_IDX_W      = 10;
  localparam int CFG_DATA_W     = 64;
  localparam int CFG_ADDR_W     = 4;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_FOUND    = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // Datapath action of one microcode step.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_APPEND,
    ACT_CLEAR,
    ACT_ACK,
    ACT_NEAR_INIT,
    ACT_ISSUE,
    ACT_LOOK_INIT,
    ACT_GOAL
  } act_t;

  // Sequencing condition of one microcode step.
  typedef enum logic [2:0] {
    CND_NEXT,
    CND_JUMP,
    CND_DISPATCH,
    CND_IF_EMPTY,
    CND_ISSUED,
    CND_DRAINED
  } cond_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'd0,
    S_APPEND = 4'd1,
    S_CLEAR  = 4'd2,
    S_ACK    = 4'd3,
    S_QUERY  = 4'd4,
    S_NEAR   = 4'd5,
    S_NDRAIN = 4'd6,
    S_LOOKI  = 4'd7,
    S_LOOK   = 4'd8,
    S_LDRAIN = 4'd9,
    S_GOAL   = 4'd10,
    S_EMPTY  = 4'd11
  } step_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
  } ctrl_t;

  // Control store: one word per step.
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    case (s)
      S_IDLE:   w = '{act: ACT_NONE,      cond: CND_DISPATCH, target: S_IDLE};
      S_APPEND: w = '{act: ACT_APPEND,    cond: CND_JUMP,     target: S_IDLE};
      S_CLEAR:  w = '{act: ACT_CLEAR,     cond: CND_JUMP,     target: S_IDLE};
      S_ACK:    w = '{act: ACT_ACK,       cond: CND_JUMP,     target: S_IDLE};
      S_QUERY:  w = '{act: ACT_NEAR_INIT, cond: CND_IF_EMPTY, target: S_EMPTY};
      S_NEAR:   w = '{act: ACT_ISSUE,     cond: CND_ISSUED,   target: S_NDRAIN};
      S_NDRAIN: w = '{act: ACT_NONE,      cond: CND_DRAINED,  target: S_LOOKI};
      S_LOOKI:  w = '{act: ACT_LOOK_INIT, cond: CND_NEXT,     target: S_LOOK};
      S_LOOK:   w = '{act: ACT_ISSUE,     cond: CND_ISSUED,   target: S_LDRAIN};
      S_LDRAIN: w = '{act: ACT_NONE,      cond: CND_DRAINED,  target: S_GOAL};
      S_GOAL:   w = '{act: ACT_GOAL,      cond: CND_JUMP,     target: S_IDLE};
      S_EMPTY:  w = '{act: ACT_ACK,       cond: CND_JUMP,     target: S_IDLE};
      default:  w = '{act: ACT_NONE,      cond: CND_JUMP,     target: S_IDLE};
    endcase
    return w;
  endfunction

  // Entry step for each operation code.
  function automatic step_t dispatch(input op_t op);
    step_t s;
    case (op)
      OP_APPEND: s = S_APPEND;
      OP_CLEAR:  s = S_CLEAR;
      OP_QUERY:  s = S_QUERY;
      default:   s = S_ACK;
    endcase
    return s;
  endfunction

endpackage

// ===== src/lookahead_goal_selector.sv =====
// Lookahead goal selector: point table, microcoded sequencer and distance pipeline.
//
// Points are appended one per command into an on-chip table; a clear command
// empties it and a query returns the first point beyond the lookahead radius,
// walking forward from the point nearest the robot, or the point before the
// nearest if none is beyond. Every command gives exactly one result, shown for
// one cycle on out_valid; the receiver cannot stall, so capture it when
// out_valid is high. busy is high from the cycle after start is taken until the
// result cycle. A query makes a nearest-point pass and a lookahead pass: the
// single table read port steps one entry per cycle through each, and the
// five-stage distance pipeline fills and drains once per pass. An empty table
// answers a query with status empty and makes neither pass.
module lookahead_goal_selector #(
  parameter int MAX_POINTS = lgs_pkg::DEF_MAX_POINTS,
  parameter int COORD_BITS = lgs_pkg::DEF_COORD_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            in_operation,
  input  logic signed [COORD_BITS-1:0]          in_point_x,
  input  logic signed [COORD_BITS-1:0]          in_point_y,
  input  logic signed [COORD_BITS-1:0]          in_robot_x,
  input  logic signed [COORD_BITS-1:0]          in_robot_y,
  output logic                                  out_valid,
  output logic [1:0]                            out_status,
  output logic signed [COORD_BITS-1:0]          out_goal_x,
  output logic signed [COORD_BITS-1:0]          out_goal_y,
  output logic [lgs_pkg::OUT_IDX_W-1:0]         out_goal_idx,
  output logic [lgs_pkg::OUT_IDX_W-1:0]         out_near_idx,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [lgs_pkg::CFG_ADDR_W-1:0]        paddr,
  input  logic [lgs_pkg::CFG_DATA_W-1:0]        pwdata,
  output logic [lgs_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                  pready
);
  import lgs_pkg::*;

  localparam int IW  = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int PW  = 2 * COORD_BITS;
  localparam int FW  = 2 * COORD_BITS + 1;
  localparam int SW  = (FW > 64) ? 64 : FW;
  localparam int CMW = 64;

  // Configuration
  logic [LA_W-1:0] la_r;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[CFG_ADDR_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      la_r <= LA_RESET;
    end else if (cfg_wr) begin
      la_r <= pwdata[LA_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (!paddr[CFG_ADDR_W-1]) begin
      prdata = CFG_DATA_W'(la_r);
    end
  end

  // Sequencer
  step_t pc_r, pc_nxt;
  ctrl_t cw;
  logic  accept;
  logic  issue;
  logic  pipe_busy;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic [IW-1:0] addr_r, addr_nxt;
  logic [CW-1:0] addr_inc;

  assign cw     = ucode(pc_r);
  assign busy   = (pc_r != S_IDLE);
  assign accept = start && !busy;
  assign issue  = (cw.act == ACT_ISSUE) && (left_r != '0);

  always_comb begin
    pc_nxt = pc_r;
    case (cw.cond)
      CND_NEXT: pc_nxt = step_t'(pc_r + 4'd1);
      CND_JUMP: pc_nxt = cw.target;
      CND_DISPATCH: begin
        if (start) begin
          pc_nxt = dispatch(op_t'(in_operation));
        end
      end
      CND_IF_EMPTY: pc_nxt = (count_r == '0) ? cw.target : step_t'(pc_r + 4'd1);
      CND_ISSUED: begin
        if (left_r <= CW'(1)) begin
          pc_nxt = cw.target;
        end
      end
      CND_DRAINED: begin
        if (!pipe_busy) begin
          pc_nxt = cw.target;
        end
      end
      default: pc_nxt = S_IDLE;
    endcase
  end

  // Latched command operands
  logic signed [COORD_BITS-1:0] px_r, py_r, rx_r, ry_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      px_r <= in_point_x;
      py_r <= in_point_y;
      rx_r <= in_robot_x;
      ry_r <= in_robot_y;
    end
  end

  // Point table
  logic [PW-1:0] mem [MAX_POINTS];
  logic [PW-1:0] rd_r;
  logic          wr_en;

  assign wr_en = (cw.act == ACT_APPEND) && (count_r != CW'(MAX_POINTS));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IW-1:0]] <= {px_r, py_r};
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= mem[addr_r];
  end

  // Distance pipeline: read, abs diff, square, sum, compare
  logic v1_r, v2_r, v3_r, v4_r;
  logic [IW-1:0] idx1_r, idx2_r, idx3_r, idx4_r;
  logic signed [COORD_BITS-1:0] x2_r, y2_r, x3_r, y3_r, x4_r, y4_r;
  logic [COORD_BITS-1:0] dx_r, dy_r;
  logic [PW-1:0] sx_r, sy_r;
  logic [SW-1:0] d_r;
  logic [FW-1:0] sum_full;

  function automatic logic [COORD_BITS-1:0] abs_diff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic signed [COORD_BITS:0] d;
    logic signed [COORD_BITS:0] m;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    m = d[COORD_BITS] ? -d : d;
    return m[COORD_BITS-1:0];
  endfunction

  assign pipe_busy = v1_r || v2_r || v3_r || v4_r;
  assign sum_full  = FW'(sx_r) + FW'(sy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    idx1_r <= addr_r;
    idx2_r <= idx1_r;
    x2_r   <= rd_r[PW-1:COORD_BITS];
    y2_r   <= rd_r[COORD_BITS-1:0];
    dx_r   <= abs_diff(rd_r[PW-1:COORD_BITS], rx_r);
    dy_r   <= abs_diff(rd_r[COORD_BITS-1:0], ry_r);
    idx3_r <= idx2_r;
    x3_r   <= x2_r;
    y3_r   <= y2_r;
    sx_r   <= PW'(dx_r) * PW'(dx_r);
    sy_r   <= PW'(dy_r) * PW'(dy_r);
    idx4_r <= idx3_r;
    x4_r   <= x3_r;
    y4_r   <= y3_r;
    // saturate when the sum leaves the SW-bit range (SW is at most 64)
    d_r    <= ((sum_full >> SW) != '0) ? '1 : sum_full[SW-1:0];
  end

  // Search state
  logic          look_r, look_nxt;
  logic          best_vld_r, best_vld_nxt;
  logic          found_r, found_nxt;
  logic [SW-1:0] best_r, best_nxt;
  logic [IW-1:0] nearest_r, nearest_nxt;
  logic [IW-1:0] goal_r, goal_nxt;
  logic signed [COORD_BITS-1:0] gx_r, gx_nxt, gy_r, gy_nxt;

  logic                           ov_nxt;
  status_t                        ost_nxt;
  logic signed [COORD_BITS-1:0]   ox_nxt, oy_nxt;
  logic [OUT_IDX_W-1:0]           ogi_nxt, oni_nxt;

  assign addr_inc = CW'(addr_r) + CW'(1);

  always_comb begin
    count_nxt    = count_r;
    left_nxt     = left_r;
    addr_nxt     = addr_r;
    look_nxt     = look_r;
    best_vld_nxt = best_vld_r;
    found_nxt    = found_r;
    best_nxt     = best_r;
    nearest_nxt  = nearest_r;
    goal_nxt     = goal_r;
    gx_nxt       = gx_r;
    gy_nxt       = gy_r;
    ov_nxt       = 1'b0;
    ost_nxt      = ST_ACCEPTED;
    ox_nxt       = '0;
    oy_nxt       = '0;
    ogi_nxt      = '0;
    oni_nxt      = '0;

    case (cw.act)
      ACT_APPEND: begin
        ov_nxt = 1'b1;
        if (count_r == CW'(MAX_POINTS)) begin
          ost_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      ACT_CLEAR: begin
        ov_nxt    = 1'b1;
        count_nxt = '0;
      end
      ACT_ACK: begin
        ov_nxt  = 1'b1;
        ost_nxt = (pc_r == S_EMPTY) ? ST_EMPTY : ST_ACCEPTED;
      end
      ACT_NEAR_INIT: begin
        look_nxt     = 1'b0;
        best_vld_nxt = 1'b0;
        addr_nxt     = '0;
        left_nxt     = count_r;
      end
      ACT_LOOK_INIT: begin
        look_nxt  = 1'b1;
        found_nxt = 1'b0;
        addr_nxt  = nearest_r;
        left_nxt  = count_r;
      end
      ACT_ISSUE: begin
        if (issue) begin
          left_nxt = left_r - CW'(1);
          // wrap past the last stored point
          addr_nxt = (addr_inc == count_r) ? '0 : addr_inc[IW-1:0];
        end
      end
      ACT_GOAL: begin
        ov_nxt  = 1'b1;
        ost_nxt = ST_FOUND;
        ox_nxt  = gx_r;
        oy_nxt  = gy_r;
        ogi_nxt = OUT_IDX_W'(goal_r);
        oni_nxt = OUT_IDX_W'(nearest_r);
      end
      default: ;
    endcase

    // compare stage
    if (v4_r) begin
      if (!look_r) begin
        if (!best_vld_r || (d_r < best_r)) begin
          best_vld_nxt = 1'b1;
          best_nxt     = d_r;
          nearest_nxt  = idx4_r;
        end
      end else if (!found_r) begin
        goal_nxt = idx4_r;
        gx_nxt   = x4_r;
        gy_nxt   = y4_r;
        if (CMW'(d_r) > CMW'(la_r)) begin
          found_nxt = 1'b1;
        end
      end
    end
  end

  // Result register
  logic                         ov_r;
  status_t                      ost_r;
  logic signed [COORD_BITS-1:0] ox_r, oy_r;
  logic [OUT_IDX_W-1:0]         ogi_r, oni_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r       <= S_IDLE;
      count_r    <= '0;
      left_r     <= '0;
      addr_r     <= '0;
      look_r     <= 1'b0;
      best_vld_r <= 1'b0;
      found_r    <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      pc_r       <= pc_nxt;
      count_r    <= count_nxt;
      left_r     <= left_nxt;
      addr_r     <= addr_nxt;
      look_r     <= look_nxt;
      best_vld_r <= best_vld_nxt;
      found_r    <= found_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r    <= best_nxt;
    nearest_r <= nearest_nxt;
    goal_r    <= goal_nxt;
    gx_r      <= gx_nxt;
    gy_r      <= gy_nxt;
    ost_r     <= ost_nxt;
    ox_r      <= ox_nxt;
    oy_r      <= oy_nxt;
    ogi_r     <= ogi_nxt;
    oni_r     <= oni_nxt;
  end

  assign out_valid    = ov_r;
  assign out_status   = ost_r;
  assign out_goal_x   = ox_r;
  assign out_goal_y   = oy_r;
  assign out_goal_idx = ogi_r;
  assign out_near_idx = oni_r;

endmodule

// ===== tb/sv/lookahead_goal_selector_test.sv =====
// Self-checking testbench for the lookahead goal selector: command driver, APB setup, goal scoreboard.
`timescale 1ns / 1ps

module lookahead_goal_selector_test;
  import lgs_pkg::*;

  localparam int MAX_PTS = DEF_MAX_POINTS;
  localparam int COORD_W = DEF_COORD_BITS;
  localparam logic [CFG_ADDR_W-1:0] REG_LOOKAHEAD_SQ = 'd0;
  localparam logic [LA_W-1:0] LA_MAX = {LA_W{1'b1}};

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam coord_t C_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  typedef struct packed {
    status_t status;
    coord_t goal_x;
    coord_t goal_y;
    logic [OUT_IDX_W-1:0] goal_idx;
    logic [OUT_IDX_W-1:0] near_idx;
  } goal_t;

  class goal_checker;
    coord_t tab_x[MAX_PTS];
    coord_t tab_y[MAX_PTS];
    int unsigned count;
    logic [LA_W-1:0] lookahead;
    goal_t pending_goals[$];
    int errors;

    function new();
      count = 0;
      lookahead = LA_RESET;
      errors = 0;
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    // Coordinates are 24 bits, so the sum of squares fits well inside 64 bits.
    function logic [63:0] dist_sq(int unsigned i, coord_t rx, coord_t ry);
      longint dx;
      longint dy;
      dx = longint'(tab_x[i]) - longint'(rx);
      dy = longint'(tab_y[i]) - longint'(ry);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      return dx * dx + dy * dy;
    endfunction

    function goal_t apply_command(op_t op, coord_t px, coord_t py, coord_t rx, coord_t ry);
      goal_t g;
      int unsigned nearest;
      int unsigned goal;
      int unsigned t;
      logic [63:0] best;
      logic [63:0] d;
      g = '0;
      g.status = ST_ACCEPTED;
      case (op)
        OP_APPEND: begin
          if (count >= MAX_PTS) begin
            g.status = ST_FULL;
          end else begin
            tab_x[count] = px;
            tab_y[count] = py;
            count++;
          end
        end
        OP_CLEAR: count = 0;
        OP_QUERY: begin
          if (count == 0) begin
            g.status = ST_EMPTY;
          end else begin
            nearest = 0;
            best = dist_sq(0, rx, ry);
            for (int unsigned i = 1; i < count; i++) begin
              d = dist_sq(i, rx, ry);
              if (d < best) begin
                best = d;
                nearest = i;
              end
            end
            // Walk forward with wraparound; no hit leaves the point before nearest.
            goal = nearest;
            for (int unsigned i = 0; i < count; i++) begin
              t = nearest + i;
              if (t >= count) t -= count;
              goal = t;
              if (dist_sq(t, rx, ry) > {15'd0, lookahead}) break;
            end
            g.status = ST_FOUND;
            g.goal_x = tab_x[goal];
            g.goal_y = tab_y[goal];
            g.goal_idx = goal[OUT_IDX_W-1:0];
            g.near_idx = nearest[OUT_IDX_W-1:0];
          end
        end
        default: ;
      endcase
      return g;
    endfunction

    function void note_command(op_t op, coord_t px, coord_t py, coord_t rx, coord_t ry);
      pending_goals.insert(pending_goals.size(), apply_command(op, px, py, rx, ry));
    endfunction

    task check_result(logic [1:0] st, coord_t gx, coord_t gy,
                      logic [OUT_IDX_W-1:0] gi, logic [OUT_IDX_W-1:0] ni);
      goal_t e;
      if (pending_goals.size() == 0) begin
        report($sformatf("result with no command pending, status %0d", st));
      end else begin
        e = pending_goals.pop_front();
        if (st !== e.status)
          report($sformatf("status got %0d expected %0d", st, e.status));
        if (gx !== e.goal_x)
          report($sformatf("goal_x got %0d expected %0d", gx, e.goal_x));
        if (gy !== e.goal_y)
          report($sformatf("goal_y got %0d expected %0d", gy, e.goal_y));
        if (gi !== e.goal_idx)
          report($sformatf("goal_idx got %0d expected %0d", gi, e.goal_idx));
        if (ni !== e.near_idx)
          report($sformatf("near_idx got %0d expected %0d", ni, e.near_idx));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_operation = '0;
  coord_t in_point_x = '0;
  coord_t in_point_y = '0;
  coord_t in_robot_x = '0;
  coord_t in_robot_y = '0;
  logic out_valid;
  logic [1:0] out_status;
  coord_t out_goal_x;
  coord_t out_goal_y;
  logic [OUT_IDX_W-1:0] out_goal_idx;
  logic [OUT_IDX_W-1:0] out_near_idx;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  goal_checker sb = new();
  int sent = 0;
  bit gaps_on = 1'b0;

  lookahead_goal_selector i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_operation(in_operation),
    .in_point_x(in_point_x),
    .in_point_y(in_point_y),
    .in_robot_x(in_robot_x),
    .in_robot_y(in_robot_y),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_goal_x(out_goal_x),
    .out_goal_y(out_goal_y),
    .out_goal_idx(out_goal_idx),
    .out_near_idx(out_near_idx),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      sb.check_result(out_status, out_goal_x, out_goal_y, out_goal_idx, out_near_idx);
  end

  function coord_t any_coord();
    return coord_t'($urandom);
  endfunction

  function coord_t near(coord_t c, int spread);
    longint v;
    v = longint'(c) + longint'($urandom_range(2 * spread)) - spread;
    if (v > longint'(C_MAX)) v = C_MAX;
    if (v < longint'(C_MIN)) v = C_MIN;
    return coord_t'(v);
  endfunction

  task send_command(op_t op, coord_t px, coord_t py, coord_t rx, coord_t ry);
    @(negedge clk);
    // Hold start low while busy so that gaps land right where busy drops.
    if (gaps_on) begin
      while (busy || $urandom_range(99) < 31) begin
        start <= 1'b0;
        @(negedge clk);
      end
    end
    start <= 1'b1;
    in_operation <= op;
    in_point_x <= px;
    in_point_y <= py;
    in_robot_x <= rx;
    in_robot_y <= ry;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_command(op, px, py, rx, ry);
    sent++;
  endtask

  task drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending_goals.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task read_lookahead();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= REG_LOOKAHEAD_SQ;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata[LA_W-1:0] !== sb.lookahead)
      sb.report($sformatf("lookahead_sq read %0d expected %0d", prdata[LA_W-1:0], sb.lookahead));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task write_lookahead(logic [LA_W-1:0] v);
    logic [CFG_DATA_W-1:0] word;
    // Junk above the register width must be dropped.
    word = {$urandom, $urandom};
    word[LA_W-1:0] = v;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_LOOKAHEAD_SQ;
    pwdata <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.lookahead = v;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    read_lookahead();
  endtask

  task run_phase(int items, bit gaps);
    int stop;
    int spread;
    int unsigned idx;
    coord_t cx;
    coord_t cy;
    coord_t rx;
    coord_t ry;
    gaps_on = gaps;
    stop = sent + items;
    while (sent < stop) begin
      if ($urandom_range(99) < 80) begin
        // Path segment: optional clear, a cluster of points, then queries around it.
        if ($urandom_range(1) == 1)
          send_command(OP_CLEAR, any_coord(), any_coord(), any_coord(), any_coord());
        cx = any_coord();
        cy = any_coord();
        case ($urandom_range(2))
          0: spread = 64;
          1: spread = 1024;
          default: spread = 8192;
        endcase
        repeat ($urandom_range(1, 20))
          send_command(OP_APPEND, near(cx, spread), near(cy, spread), any_coord(), any_coord());
        repeat ($urandom_range(1, 4)) begin
          if (sb.count != 0 && $urandom_range(3) == 0) begin
            idx = $urandom_range(sb.count - 1);
            rx = sb.tab_x[idx];
            ry = sb.tab_y[idx];
          end else begin
            rx = near(cx, 2 * spread);
            ry = near(cy, 2 * spread);
          end
          send_command(OP_QUERY, any_coord(), any_coord(), rx, ry);
        end
      end else begin
        send_command(op_t'($urandom_range(3)), any_coord(), any_coord(), any_coord(), any_coord());
      end
    end
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    read_lookahead();

    // Directed: empty table, unused code, extremes, ties, the strict boundary, wraparound.
    gaps_on = 1'b0;
    send_command(OP_QUERY, '0, '0, '0, '0);
    send_command(OP_NONE, C_MAX, C_MIN, C_MAX, C_MIN);
    send_command(OP_CLEAR, '0, '0, '0, '0);
    send_command(OP_APPEND, C_MIN, C_MIN, '0, '0);
    send_command(OP_APPEND, C_MAX, C_MAX, '0, '0);
    send_command(OP_QUERY, '0, '0, C_MAX, C_MAX);
    send_command(OP_QUERY, '0, '0, C_MIN, C_MAX);
    send_command(OP_CLEAR, '0, '0, '0, '0);
    send_command(OP_APPEND, '0, '0, '0, '0);
    send_command(OP_APPEND, '0, '0, '0, '0);
    send_command(OP_APPEND, 24'sd512, '0, '0, '0);
    send_command(OP_APPEND, 24'sd1024, '0, '0, '0);
    send_command(OP_APPEND, 24'sd1536, '0, '0, '0);
    send_command(OP_APPEND, -24'sd256, -24'sd256, '0, '0);
    send_command(OP_QUERY, '0, '0, '0, '0);
    send_command(OP_QUERY, '0, '0, 24'sd1536, '0);
    send_command(OP_QUERY, '0, '0, -24'sd256, -24'sd256);
    send_command(OP_QUERY, '0, '0, C_MAX, C_MIN);
    send_command(OP_NONE, '0, '0, '0, '0);
    send_command(OP_CLEAR, C_MAX, C_MAX, C_MAX, C_MAX);
    send_command(OP_APPEND, 24'sd100, -24'sd100, '0, '0);
    send_command(OP_QUERY, '0, '0, 24'sd100, -24'sd100);
    send_command(OP_QUERY, '0, '0, C_MIN, C_MIN);
    drain();

    run_phase(45, 1'b1);
    write_lookahead('0);
    run_phase(45, 1'b0);
    write_lookahead(LA_MAX);
    run_phase(45, 1'b1);
    write_lookahead(LA_W'($urandom_range(1 << 24)));
    run_phase(50, 1'b1);
    write_lookahead(LA_W'({$urandom, $urandom}));
    run_phase(45, 1'b1);

    // Extreme lookahead values on the table left over, then an empty query.
    write_lookahead(LA_MAX);
    gaps_on = 1'b1;
    send_command(OP_QUERY, '0, '0, near('0, 4096), near('0, 4096));
    drain();
    write_lookahead('0);
    send_command(OP_QUERY, '0, '0, near('0, 4096), near('0, 4096));
    send_command(OP_NONE, any_coord(), any_coord(), any_coord(), any_coord());
    send_command(OP_CLEAR, '0, '0, '0, '0);
    send_command(OP_QUERY, '0, '0, any_coord(), any_coord());
    drain();

    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
